>>> src/binary_max_heap_queue_top_assert.svh
// Assertion macros shared by the heap queue RTL.
// Both forms sample on the rising edge of clk and are disabled while rst is high.
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMHQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

>>> src/bmhq_pkg.sv
package bmhq_pkg;

  // Heap storage geometry.
  localparam int DEPTH   = 256;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int CHILD_W = ADDR_W + 2;

  // Key and stream widths.
  localparam int KEY_W   = 32;
  localparam int STAT_W  = 2;
  localparam int OUT_RAW = KEY_W + STAT_W + CNT_W;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  // Operation kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

>>> src/binary_max_heap_queue_top.sv
// Max-heap priority queue of signed 32-bit keys held in a 256-entry single-port-read memory.
// Each request (tuser = 0 insert, 1 pop) gives exactly one response carrying the popped key,
// a status and the count after the request. The block takes one request at a time, and a
// single key comparator walks the heap one level per step. An insert into an empty queue
// writes the root at once; any other insert climbs while the key beats its parent. A pop
// that leaves at most one key ends after moving the last entry; any other pop sinks the
// moved key, fetching both children through the one read port. A drop on full or a pop
// on empty goes straight to the response. The response sits in its own output register,
// so the next request is taken while it waits. Capacity is written through cfg_wen/cfg_wdata;
// the user must write it only while the queue is idle, as the block does not enforce it.
// Values above 256 act as 256.
module binary_max_heap_queue_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [bmhq_pkg::CNT_W-1:0] cfg_wdata,      // capacity
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bmhq_pkg::KEY_W-1:0] s_axis_tdata,   // [31:0] key_in
  input  logic                       s_axis_tuser,   // [0] kind
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bmhq_pkg::OUT_W-1:0] m_axis_tdata    // [31:0] key_out, [33:32] status,
                                                     // [42:34] count_after, rest zero
);
  import bmhq_pkg::*;

  `include "binary_max_heap_queue_top_assert.svh"

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_CMP   = 4'd1;
  localparam logic [3:0] S_POP_LAST = 4'd2;
  localparam logic [3:0] S_POP_MOVE = 4'd3;
  localparam logic [3:0] S_DN_R     = 4'd4;
  localparam logic [3:0] S_DN_CMP   = 4'd5;
  localparam logic [3:0] S_DN_SW    = 4'd6;
  localparam logic [3:0] S_WR_KEY   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]        state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  limit;
  logic [ADDR_W-1:0] pos, pos_next;
  logic [KEY_W-1:0]  key, key_next;
  logic [KEY_W-1:0]  best, best_next;
  logic [ADDR_W-1:0] bidx, bidx_next;
  logic [KEY_W-1:0]  res_key, res_key_next;
  logic [STAT_W-1:0] res_status, res_status_next;

  logic              out_valid;
  logic [KEY_W-1:0]  out_key;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_count;
  logic              out_load;

  logic [KEY_W-1:0]  mem [DEPTH];
  logic [KEY_W-1:0]  rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [KEY_W-1:0]  mem_wd;
  logic [ADDR_W-1:0] mem_ra;

  logic [KEY_W-1:0]  cmp_a, cmp_b;
  logic              gt;
  logic              accept;

  logic [CHILD_W-1:0] lc, rc, nlc;
  logic [ADDR_W-1:0]  par;
  logic [CNT_W-1:0]   cnt_less1;
  logic [CNT_W-1:0]   par_of_cnt;

  // Shared signed key comparator.
  assign gt = $signed(cmp_a) > $signed(cmp_b);

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_load      = (state == S_DONE) && (!out_valid || m_axis_tready);

  // Effective capacity saturates at the store depth.
  assign limit = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;

  // Heap index arithmetic.
  assign lc         = {1'b0, pos, 1'b0} + CHILD_W'(1);
  assign rc         = {1'b0, pos, 1'b0} + CHILD_W'(2);
  assign nlc        = {1'b0, bidx, 1'b0} + CHILD_W'(1);
  assign par        = (pos - ADDR_W'(1)) >> 1;
  assign cnt_less1  = cnt - CNT_W'(1);
  assign par_of_cnt = cnt_less1 >> 1;

  // Sequencer next state, memory control and comparator operands.
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pos_next        = pos;
    key_next        = key;
    best_next       = best;
    bidx_next       = bidx;
    res_key_next    = res_key;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_wa          = pos;
    mem_wd          = key;
    mem_ra          = '0;
    cmp_a           = key;
    cmp_b           = rd_data;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_key_next    = '0;
          res_status_next = ST_OK;
          if (s_axis_tuser == KIND_INSERT) begin
            if (cnt >= limit) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else begin
              key_next = s_axis_tdata;
              pos_next = cnt[ADDR_W-1:0];
              cnt_next = cnt + CNT_W'(1);
              if (cnt == '0) begin
                mem_we     = 1'b1;
                mem_wa     = '0;
                mem_wd     = s_axis_tdata;
                state_next = S_DONE;
              end else begin
                mem_ra     = par_of_cnt[ADDR_W-1:0];
                state_next = S_UP_CMP;
              end
            end
          end else begin
            if (cnt == '0) begin
              res_key_next    = KEY_MIN;
              res_status_next = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              mem_ra     = '0;
              state_next = S_POP_LAST;
            end
          end
        end
      end

      // Climb while the new key beats its parent, moving parents down.
      S_UP_CMP: begin
        cmp_a = key;
        cmp_b = rd_data;
        if (gt) begin
          mem_we   = 1'b1;
          mem_wa   = pos;
          mem_wd   = rd_data;
          pos_next = par;
          if (par != '0) begin
            mem_ra = (par - ADDR_W'(1)) >> 1;
          end else begin
            state_next = S_WR_KEY;
          end
        end else begin
          mem_we     = 1'b1;
          mem_wa     = pos;
          mem_wd     = key;
          state_next = S_DONE;
        end
      end

      // Root arrives; fetch the last entry.
      S_POP_LAST: begin
        res_key_next = rd_data;
        mem_ra       = cnt_less1[ADDR_W-1:0];
        cnt_next     = cnt_less1;
        state_next   = S_POP_MOVE;
      end

      // Last entry arrives and, unless it was the popped root itself, becomes the key that sinks from the root.
      S_POP_MOVE: begin
        key_next = rd_data;
        pos_next = '0;
        if (cnt == '0) begin
          state_next = S_DONE;
        end else if (cnt == CNT_W'(1)) begin
          mem_we     = 1'b1;
          mem_wa     = '0;
          mem_wd     = rd_data;
          state_next = S_DONE;
        end else begin
          mem_ra     = ADDR_W'(1);
          state_next = S_DN_R;
        end
      end

      // Left child arrives; fetch the right one if it exists.
      S_DN_R: begin
        best_next = rd_data;
        bidx_next = lc[ADDR_W-1:0];
        if (rc < CHILD_W'(cnt)) begin
          mem_ra     = rc[ADDR_W-1:0];
          state_next = S_DN_CMP;
        end else begin
          state_next = S_DN_SW;
        end
      end

      // The right child wins only when strictly larger than the left.
      S_DN_CMP: begin
        cmp_a = rd_data;
        cmp_b = best;
        if (gt) begin
          best_next = rd_data;
          bidx_next = rc[ADDR_W-1:0];
        end
        state_next = S_DN_SW;
      end

      // Move the larger child up while it beats the sinking key.
      S_DN_SW: begin
        cmp_a = best;
        cmp_b = key;
        if (gt) begin
          mem_we   = 1'b1;
          mem_wa   = pos;
          mem_wd   = best;
          pos_next = bidx;
          if (nlc < CHILD_W'(cnt)) begin
            mem_ra     = nlc[ADDR_W-1:0];
            state_next = S_DN_R;
          end else begin
            state_next = S_WR_KEY;
          end
        end else begin
          mem_we     = 1'b1;
          mem_wa     = pos;
          mem_wd     = key;
          state_next = S_DONE;
        end
      end

      S_WR_KEY: begin
        mem_we     = 1'b1;
        mem_wa     = pos;
        mem_wd     = key;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Heap store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      capacity  <= CNT_W'(DEPTH);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    key        <= key_next;
    best       <= best_next;
    bidx       <= bidx_next;
    res_key    <= res_key_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_key    <= res_key;
      out_status <= res_status;
      out_count  <= cnt;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_W - OUT_RAW)'(0), out_count, out_status, out_key};

  // Checks on the sequencer and the count.
  `BMHQ_ASSERT_SAME(a_cnt_bound, 1'b1, cnt <= CNT_W'(DEPTH))
  `BMHQ_ASSERT_NEXT(a_busy_after_request, accept, state != S_IDLE)
  `BMHQ_ASSERT_SAME(a_empty_means_zero, out_load && (res_status == ST_EMPTY), cnt == '0)
  `BMHQ_ASSERT_SAME(a_no_write_idle, (state == S_IDLE) && !accept, !mem_we)
  `BMHQ_ASSERT_NEXT(a_cnt_steady, !accept && (state != S_POP_LAST), $stable(cnt))

endmodule
